// ===== rtl/core/dfq_pkg.sv =====
// Package for the deferred-reuse free page queue.
// Holds sizes, operation and status codes, and the item and memory request types.
// Has no dependencies; dfq_ctrl, the top and the testbench files import it.
package dfq_pkg;

   // Sizes of each queue and of the stored fields
   localparam int QUEUE_DEPTH = 1024;
   localparam int TID_BITS    = 48;
   localparam int PAGE_BITS   = 32;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W      = IDX_W + 1;
   localparam int MEM_DEPTH   = 2 * (2 ** IDX_W);

   typedef logic [1:0]           func_type;
   typedef logic [1:0]           status_type;
   typedef logic [PAGE_BITS-1:0] page_type;
   typedef logic [TID_BITS-1:0]  tid_type;
   typedef logic [IDX_W-1:0]     idx_type;
   typedef logic [CNT_W-1:0]     cnt_type;

   // Operation codes
   localparam func_type FN_INSERT = 2'd0;
   localparam func_type FN_ALLOC  = 2'd1;
   localparam func_type FN_DRAIN  = 2'd2;

   // Result status codes
   localparam status_type STAT_OK    = 2'd0;
   localparam status_type STAT_EMPTY = 2'd1;
   localparam status_type STAT_NYS   = 2'd2;
   localparam status_type STAT_FULL  = 2'd3;

   typedef struct packed {
      func_type func;
      logic     pool;
      page_type page_number;
      tid_type  free_tid;
      tid_type  safe_tid;
   } req_type;

   typedef struct packed {
      page_type   out_page;
      tid_type    out_tid;
      status_type status;
      cnt_type    occupancy;
   } rsp_type;

   // One access to the entry memories: address is {pool, slot}
   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [ADDR_W-1:0] addr;
   } mem_req_type;

endpackage

// ===== rtl/core/dfq_ram.sv =====
// Generic single-port RAM with registered read data.
// Used for the page and tid entry stores; no dependencies.
module dfq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write on request; register read data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/dfq_ctrl.sv =====
// Queue controller: head and fill registers per pool, operation sequencing,
// memory requests and the result register. Depends on dfq_pkg.
module dfq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  dfq_pkg::req_type     req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output dfq_pkg::rsp_type     rsp_data,
   output dfq_pkg::mem_req_type mem_req,
   output dfq_pkg::page_type    mem_wr_page,
   output dfq_pkg::tid_type     mem_wr_tid,
   input  dfq_pkg::page_type    mem_rd_page,
   input  dfq_pkg::tid_type     mem_rd_tid
);
   import dfq_pkg::*;

   localparam int SUM_W = CNT_W + 1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } state_type;

   state_type  state_ff, state_in;
   idx_type    head_ff [2];
   idx_type    head_in [2];
   cnt_type    cnt_ff [2];
   cnt_type    cnt_in [2];
   func_type   op_ff, op_in;
   logic       pool_ff, pool_in;
   tid_type    safe_ff, safe_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;

   logic             accept;
   logic             load;
   rsp_type          res;
   idx_type          head_sel;
   cnt_type          cnt_sel;
   idx_type          head_dec;
   logic [SUM_W-1:0] tail_sum;
   idx_type          tail_idx;
   idx_type          head_cur;
   cnt_type          cnt_cur;
   idx_type          head_inc;

   // Stall while a pop waits on memory or the result register is held
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   // Slot arithmetic for the incoming item
   always_comb begin
      head_sel = head_ff[req_data.pool];
      cnt_sel  = cnt_ff[req_data.pool];
      head_dec = (head_sel == '0) ? IDX_W'(QUEUE_DEPTH - 1) : head_sel - IDX_W'(1);
      tail_sum = SUM_W'(head_sel) + SUM_W'(cnt_sel);
      tail_idx = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                 IDX_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : IDX_W'(tail_sum);
   end

   // Slot arithmetic for the pop in flight
   always_comb begin
      head_cur = head_ff[pool_ff];
      cnt_cur  = cnt_ff[pool_ff];
      head_inc = (head_cur == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_cur + IDX_W'(1);
   end

   assign mem_wr_page = req_data.page_number;
   assign mem_wr_tid  = req_data.free_tid;

   // Sequence operations
   always_comb begin
      state_in = state_ff;
      head_in  = head_ff;
      cnt_in   = cnt_ff;
      op_in    = op_ff;
      pool_in  = pool_ff;
      safe_in  = safe_ff;
      mem_req  = '0;
      load     = 1'b0;
      res      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (req_data.func == FN_INSERT) begin
                  load          = 1'b1;
                  res.occupancy = cnt_sel;
                  if (cnt_sel == CNT_W'(QUEUE_DEPTH)) begin
                     res.status = STAT_FULL;
                  end else begin
                     mem_req.wr_en = 1'b1;
                     if (req_data.free_tid == '0) begin
                        // reusable at once: push at the front
                        mem_req.addr            = {req_data.pool, head_dec};
                        head_in[req_data.pool] = head_dec;
                     end else begin
                        mem_req.addr = {req_data.pool, tail_idx};
                     end
                     cnt_in[req_data.pool] = cnt_sel + CNT_W'(1);
                     res.occupancy         = cnt_sel + CNT_W'(1);
                  end
               end else if (req_data.func == FN_ALLOC || req_data.func == FN_DRAIN) begin
                  if (cnt_sel == '0) begin
                     load       = 1'b1;
                     res.status = STAT_EMPTY;
                  end else begin
                     // fetch the front entry
                     mem_req.rd_en = 1'b1;
                     mem_req.addr  = {req_data.pool, head_sel};
                     op_in         = req_data.func;
                     pool_in       = req_data.pool;
                     safe_in       = req_data.safe_tid;
                     state_in      = ST_READ;
                  end
               end else begin
                  load          = 1'b1;
                  res.occupancy = cnt_sel;
               end
            end
         end
         ST_READ: begin
            load     = 1'b1;
            state_in = ST_IDLE;
            if (op_ff == FN_ALLOC && mem_rd_tid > safe_ff) begin
               res.status    = STAT_NYS;
               res.occupancy = cnt_cur;
            end else begin
               res.out_page     = mem_rd_page;
               res.out_tid      = mem_rd_tid;
               head_in[pool_ff] = head_inc;
               cnt_in[pool_ff]  = cnt_cur - CNT_W'(1);
               res.occupancy    = cnt_cur - CNT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the result until taken
   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
         rsp_in       = rsp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '{default: '0};
         cnt_ff       <= '{default: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      pool_ff <= pool_in;
      safe_ff <= safe_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/core/deferred_reuse_free_page_queue_top.sv =====
// Deferred-reuse free page queue: two circular queues (physical pool 0, logical
// pool 1) of freed pages with the tid that freed them, kept in two entry RAMs
// of 2*QUEUE_DEPTH words with head and fill registers per pool. An insert or an
// unused operation code gives its result in the cycle after acceptance, and the
// next item may follow at once unless a held result stalls it; an allocate or
// drain on a non-empty queue reads the front entry into the registered RAM read
// data, then the result register, taking no new item meanwhile. The block is
// usable directly after reset with no clearing pass.
// Depends on dfq_pkg, dfq_ram and dfq_ctrl.
module deferred_reuse_free_page_queue_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dfq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dfq_pkg::rsp_type rsp_data
);
   import dfq_pkg::*;

   mem_req_type mem_req;
   page_type    mem_wr_page;
   tid_type     mem_wr_tid;
   page_type    mem_rd_page;
   tid_type     mem_rd_tid;

   // Sequencing, pointers and result register
   dfq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .mem_req     (mem_req),
      .mem_wr_page (mem_wr_page),
      .mem_wr_tid  (mem_wr_tid),
      .mem_rd_page (mem_rd_page),
      .mem_rd_tid  (mem_rd_tid)
   );

   // Page numbers of both pools
   dfq_ram #(
      .WIDTH (PAGE_BITS),
      .DEPTH (MEM_DEPTH)
   ) u_page_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .rd_en   (mem_req.rd_en),
      .addr    (mem_req.addr),
      .wr_data (mem_wr_page),
      .rd_data (mem_rd_page)
   );

   // Freeing tids of both pools
   dfq_ram #(
      .WIDTH (TID_BITS),
      .DEPTH (MEM_DEPTH)
   ) u_tid_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .rd_en   (mem_req.rd_en),
      .addr    (mem_req.addr),
      .wr_data (mem_wr_tid),
      .rd_data (mem_rd_tid)
   );

`ifndef SYNTH
   // A memory access only happens for an accepted item
   a_mem_on_accept: assert property (@(posedge clock) disable iff (reset)
      (mem_req.wr_en || mem_req.rd_en) |-> (req_valid && !req_stall))
      else $error("memory access without an accepted item");

   // A front read yields a result once its data has been registered
   a_read_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      mem_req.rd_en |-> ##2 rsp_valid)
      else $error("front read did not produce a result");

   // Refused or failed operations return no page
   a_no_page_on_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STAT_OK) |->
      (rsp_data.out_page == '0 && rsp_data.out_tid == '0))
      else $error("page returned with a failing status");
`endif

endmodule

// ===== dv/free_page_queue_checker.sv =====
`timescale 1ns / 100ps
// Checker for the deferred-reuse free page queue. It mirrors both page queues,
// works out the result of every accepted item, and compares the returned items.
// Depends on dfq_pkg for the item types, sizes and operation and status codes.
module free_page_queue_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  dfq_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  dfq_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending,
   output int               checked,
   output int               full_seen,
   output int               nys_seen
);
   import dfq_pkg::*;

   // Mirror of both queues: entry of pool q, slot s sits at q*QUEUE_DEPTH + s
   page_type mirror_page [2*QUEUE_DEPTH];
   tid_type  mirror_tid  [2*QUEUE_DEPTH];
   int       mirror_head [2];
   int       mirror_fill [2];

   // Results owed by the block, oldest first
   rsp_type  owed_results [$];

   initial begin
      mirror_head[0] = 0;
      mirror_head[1] = 0;
      mirror_fill[0] = 0;
      mirror_fill[1] = 0;
   end

   // Apply one item to the mirror and return the result it must produce
   function automatic rsp_type apply_to_queues(input req_type item);
      rsp_type res;
      int      q;
      int      slot;
      res = '0;
      q   = item.pool ? 1 : 0;
      case (item.func)
         FN_INSERT: begin
            if (mirror_fill[q] >= QUEUE_DEPTH) begin
               res.status = STAT_FULL;
            end else begin
               // zero tid goes in front of the head, anything else at the tail
               if (item.free_tid == '0) begin
                  mirror_head[q] = (mirror_head[q] + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
                  slot = mirror_head[q];
               end else begin
                  slot = (mirror_head[q] + mirror_fill[q]) % QUEUE_DEPTH;
               end
               mirror_page[q*QUEUE_DEPTH + slot] = item.page_number;
               mirror_tid[q*QUEUE_DEPTH + slot]  = item.free_tid;
               mirror_fill[q]++;
               res.status = STAT_OK;
            end
         end
         FN_ALLOC, FN_DRAIN: begin
            if (mirror_fill[q] == 0) begin
               res.status = STAT_EMPTY;
            end else begin
               slot = q*QUEUE_DEPTH + mirror_head[q];
               if (item.func == FN_ALLOC && mirror_tid[slot] > item.safe_tid) begin
                  res.status = STAT_NYS;
               end else begin
                  res.out_page   = mirror_page[slot];
                  res.out_tid    = mirror_tid[slot];
                  res.status     = STAT_OK;
                  mirror_head[q] = (mirror_head[q] + 1) % QUEUE_DEPTH;
                  mirror_fill[q]--;
               end
            end
         end
         default: begin
            res.status = STAT_OK;
         end
      endcase
      res.occupancy = cnt_type'(mirror_fill[q]);
      return res;
   endfunction

   // Compare returned items first, then record what new items will owe
   always @(posedge clock) begin : watch
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_results.size() == 0) begin
               $error("result item with none outstanding: %p", rsp_data);
               fail_count++;
            end else begin
               want = owed_results.pop_front();
               checked++;
               if (want.status == STAT_FULL) full_seen++;
               if (want.status == STAT_NYS) nys_seen++;
               if (rsp_data.out_page !== want.out_page) begin
                  $error("out_page: expected %h, got %h", want.out_page, rsp_data.out_page);
                  fail_count++;
               end
               if (rsp_data.out_tid !== want.out_tid) begin
                  $error("out_tid: expected %h, got %h", want.out_tid, rsp_data.out_tid);
                  fail_count++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  fail_count++;
               end
               if (rsp_data.occupancy !== want.occupancy) begin
                  $error("occupancy: expected %0d, got %0d",
                         want.occupancy, rsp_data.occupancy);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            owed_results.push_back(apply_to_queues(req_data));
         end
      end
      pending = owed_results.size();
   end

endmodule

// ===== dv/tb_deferred_reuse_free_page_queue_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the deferred-reuse free page queue: clock, reset, item
// stimulus and result back-pressure, with the verdict taken from the checker.
// Depends on dfq_pkg, free_page_queue_checker and the block's RTL.
module tb_deferred_reuse_free_page_queue_top;
   import dfq_pkg::*;

   localparam func_type FN_UNUSED   = 2'd3;
   localparam logic     POOL_PHYS   = 1'b0;
   localparam logic     POOL_LOGI   = 1'b1;
   localparam tid_type  TID_MAX     = '1;
   localparam int       CYCLE_LIMIT = 400000;
   localparam int       LONG_HOLD   = 300;

   typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int fail_count;
   int pending;
   int checked;
   int full_seen;
   int nys_seen;

   int cycle_count = 0;
   int burst_left  = 0;
   int hold_asks   = 0;
   int n_insert    = 0;
   int n_alloc     = 0;
   int n_drain     = 0;
   int n_unused    = 0;

   deferred_reuse_free_page_queue_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   free_page_queue_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked),
      .full_seen  (full_seen),
      .nys_seen   (nys_seen)
   );

   always #5 clock = ~clock;

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
         $display("FAIL deferred_reuse_free_page_queue_top");
         $finish;
      end
   end

   function automatic req_type pack_req(input func_type f, input logic p,
                                        input page_type pg, input tid_type ft,
                                        input tid_type st);
      req_type item;
      item.func        = f;
      item.pool        = p;
      item.page_number = pg;
      item.free_tid    = ft;
      item.safe_tid    = st;
      return item;
   endfunction

   function automatic tid_type rand_wide_tid();
      tid_type t;
      t[TID_BITS-1:32] = (TID_BITS-32)'($urandom);
      t[31:0]          = $urandom;
      return t;
   endfunction

   // Freeing tid: immediate reuse, small epochs, or anywhere in the range
   function automatic tid_type rand_free_tid();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 2) return '0;
      if (pick < 6) return tid_type'($urandom_range(1, 64));
      if (pick < 9) return rand_wide_tid();
      return TID_MAX;
   endfunction

   function automatic tid_type rand_safe_tid();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 4) return tid_type'($urandom_range(0, 64));
      if (pick < 8) return rand_wide_tid();
      if (pick < 9) return '0;
      return TID_MAX;
   endfunction

   // Weighted mix of operations; what is left of 100 goes to the unused code
   function automatic req_type rand_req(input int ins_w, input int alloc_w,
                                        input int drain_w, input int logi_pct);
      int       pick;
      func_type f;
      pick = $urandom_range(0, 99);
      if (pick < ins_w) f = FN_INSERT;
      else if (pick < ins_w + alloc_w) f = FN_ALLOC;
      else if (pick < ins_w + alloc_w + drain_w) f = FN_DRAIN;
      else f = FN_UNUSED;
      return pack_req(f, ($urandom_range(0, 99) < logi_pct) ? POOL_LOGI : POOL_PHYS,
                      $urandom, rand_free_tid(), rand_safe_tid());
   endfunction

   // Offer one item in bursts with random gaps; hold it until accepted
   task automatic offer(input req_type item);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!(req_valid && !req_stall));
      case (item.func)
         FN_INSERT: n_insert++;
         FN_ALLOC:  n_alloc++;
         FN_DRAIN:  n_drain++;
         default:   n_unused++;
      endcase
   endtask

   // Stop offering until every owed result has come back
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending != 0) @(negedge clock);
   endtask

   // Result back-pressure: changing patterns, plus long holds on request
   initial begin : receiver
      rx_mode_type mode;
      int          span;
      int          step;
      int          holds_done;
      holds_done = 0;
      forever begin
         if (holds_done < hold_asks) begin
            holds_done++;
            repeat (LONG_HOLD) begin
               @(negedge clock);
               rsp_stall <= 1'b1;
            end
         end else begin
            mode = rx_mode_type'($urandom_range(0, 3));
            span = $urandom_range(10, 120);
            for (step = 0; step < span; step++) begin
               @(negedge clock);
               case (mode)
                  RX_OPEN:  rsp_stall <= 1'b0;
                  RX_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
                  RX_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 7);
                  default:  rsp_stall <= (step % 3 == 0);
               endcase
            end
         end
      end
   end

   initial begin : stimulus
      int k;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty queues, unused code, front insert, safe gate edges
      offer(pack_req(FN_ALLOC,  POOL_PHYS, 32'h0, '0, TID_MAX));
      offer(pack_req(FN_DRAIN,  POOL_LOGI, 32'h0, '0, '0));
      offer(pack_req(FN_UNUSED, POOL_PHYS, 32'hFFFFFFFF, TID_MAX, TID_MAX));
      offer(pack_req(FN_INSERT, POOL_PHYS, 32'h0, 48'd5, '0));
      offer(pack_req(FN_INSERT, POOL_PHYS, 32'hFFFFFFFF, '0, '0));
      offer(pack_req(FN_UNUSED, POOL_PHYS, 32'h0, '0, '0));
      offer(pack_req(FN_ALLOC,  POOL_PHYS, 32'h0, '0, '0));
      offer(pack_req(FN_ALLOC,  POOL_PHYS, 32'h0, '0, 48'd4));
      offer(pack_req(FN_ALLOC,  POOL_PHYS, 32'h0, '0, 48'd5));
      offer(pack_req(FN_INSERT, POOL_LOGI, 32'hA5A5A5A5, TID_MAX, '0));
      offer(pack_req(FN_INSERT, POOL_LOGI, 32'h5A5A5A5A, 48'd1, '0));
      offer(pack_req(FN_ALLOC,  POOL_LOGI, 32'h0, '0, TID_MAX - 48'd1));
      offer(pack_req(FN_ALLOC,  POOL_LOGI, 32'h0, '0, TID_MAX));
      offer(pack_req(FN_ALLOC,  POOL_LOGI, 32'h0, '0, '0));
      offer(pack_req(FN_DRAIN,  POOL_LOGI, 32'h0, '0, '0));
      offer(pack_req(FN_INSERT, POOL_PHYS, 32'h00000001, 48'h800000000000, '0));
      offer(pack_req(FN_INSERT, POOL_PHYS, 32'h80000000, '0, '0));
      offer(pack_req(FN_UNUSED, POOL_LOGI, 32'h0, '0, '0));
      offer(pack_req(FN_DRAIN,  POOL_PHYS, 32'h0, '0, '0));
      offer(pack_req(FN_ALLOC,  POOL_PHYS, 32'h0, '0, 48'h7FFFFFFFFFFF));
      offer(pack_req(FN_DRAIN,  POOL_PHYS, 32'h0, '0, '0));
      wait_drained();

      // Random mix over both pools, with more pops than inserts
      for (k = 0; k < 600; k++) begin
         offer(rand_req(45, 30, 20, 50));
      end
      wait_drained();

      // Fill the logical pool past capacity while results are held back
      hold_asks++;
      for (k = 0; k < QUEUE_DEPTH + 4; k++) begin
         offer(pack_req(FN_INSERT, POOL_LOGI, $urandom, rand_free_tid(), rand_safe_tid()));
      end
      wait_drained();

      // Pop around the wrap of the full queue with inserts mixed in
      for (k = 0; k < 320; k++) begin
         offer(rand_req(30, 35, 33, 80));
      end
      wait_drained();
      repeat (8) @(posedge clock);

      $display("sent %0d items: %0d inserts, %0d allocates, %0d drains, %0d unused codes",
               n_insert + n_alloc + n_drain + n_unused, n_insert, n_alloc, n_drain, n_unused);
      $display("checked %0d results: %0d refused as full, %0d held as not yet safe",
               checked, full_seen, nys_seen);
      if (fail_count == 0) begin
         $display("PASS deferred_reuse_free_page_queue_top");
      end else begin
         $display("FAIL deferred_reuse_free_page_queue_top");
      end
      $finish;
   end

endmodule
